>>> hdl/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int REQ_W   = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   typedef enum logic [REQ_W-1:0] {
      REQ_INS_HEAD = 3'd0,
      REQ_INS_POS  = 3'd1,
      REQ_INS_TAIL = 3'd2,
      REQ_REM_HEAD = 3'd3,
      REQ_REM_POS  = 3'd4,
      REQ_REM_TAIL = 3'd5,
      REQ_SEARCH   = 3'd6,
      REQ_UNUSED   = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LEFT  = 2'd2,
      CELL_FROM_RIGHT = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        search;
      logic        live;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

>>> hdl/positional_list_engine.sv
// Top level of the positional list engine: request decode, cell row and response register.
//
// Usage:
//   req channel: tuser[2:0] carries the request code, tdata carries value and
//   position. A word is taken when req_tvalid and req_tready are both high.
//   rsp channel: one response word per request, in request order.
//   Inserts and removes shift the affected entries of the cell row and load the
//   response register in the same cycle.
//   In a search, every live cell compares and registers its match bit,
//   then a find-first-set over the match row forms the position.
//   req_tready is low during the search scan cycle and while a response waits
//   in the output register that the receiver is not taking; a response held
//   by rsp_tready low stays stable until taken.
//   Reset empties the list and drops any pending response; entry contents are
//   not cleared, since no request reads past the entry count.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // value[31:0], position[36:32], zero fill
   input  logic [REQ_W-1:0]       req_tuser,  // req_type[2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // ok, found_position[5:1],
                                              // entry_count[10:6], is_full, is_empty
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);
   localparam logic [CMPW-1:0] ONE_C = CMPW'(1);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0]   out_data_ff, out_data_in;

   logic [VALUE_W-1:0]       req_value;
   logic [POS_W-1:0]         req_pos;
   req_code_type             req_code;
   logic                     accept;

   logic [CMPW-1:0]          cnt, pos, ins_idx, rem_idx, cnt_next;
   logic                     ins_op, rem_op, ins_ok, rem_ok;

   cell_ctrl_type            cell_ctrl [CAPACITY];
   logic [VALUE_W-1:0]       cell_entry [CAPACITY];
   logic [CAPACITY-1:0]      match_row, match_low;
   logic [CMPW-1:0]          found_idx;

   assign req_value = req_tdata[VALUE_W-1:0];
   assign req_pos   = req_tdata[VALUE_W+POS_W-1:VALUE_W];
   assign req_code  = req_code_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign cnt = CMPW'(count_ff);
   assign pos = CMPW'(req_pos);

   always_comb begin
      ins_op  = 1'b0;
      rem_op  = 1'b0;
      ins_idx = '0;
      rem_idx = '0;
      case (req_code)
         REQ_INS_HEAD: begin
            ins_op = 1'b1;
         end
         REQ_INS_POS: begin
            ins_op  = (pos != '0);
            ins_idx = pos - ONE_C;
         end
         REQ_INS_TAIL: begin
            ins_op  = 1'b1;
            ins_idx = cnt;
         end
         REQ_REM_HEAD: begin
            rem_op = 1'b1;
         end
         REQ_REM_POS: begin
            rem_op  = (pos != '0);
            rem_idx = pos - ONE_C;
         end
         REQ_REM_TAIL: begin
            rem_op  = (cnt != '0);
            rem_idx = cnt - ONE_C;
         end
         default: begin
            ins_op = 1'b0;
         end
      endcase
      ins_ok = ins_op && (cnt < CAP_C) && (ins_idx <= cnt);
      rem_ok = rem_op && (cnt != '0) && (rem_idx < cnt);
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctrl[i].op     = CELL_HOLD;
         cell_ctrl[i].search = accept && (req_code == REQ_SEARCH);
         cell_ctrl[i].live   = CMPW'(i) < cnt;
         if (accept && ins_ok) begin
            if (CMPW'(i) == ins_idx) begin
               cell_ctrl[i].op = CELL_LOAD;
            end else if ((CMPW'(i) > ins_idx) && (CMPW'(i) <= cnt)) begin
               cell_ctrl[i].op = CELL_FROM_LEFT;
            end
         end else if (accept && rem_ok) begin
            if ((CMPW'(i) >= rem_idx) && ((CMPW'(i) + ONE_C) < cnt)) begin
               cell_ctrl[i].op = CELL_FROM_RIGHT;
            end
         end
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_entry, right_entry;
      if (g == 0) begin : g_first
         assign left_entry = req_value;
      end else begin : g_mid_left
         assign left_entry = cell_entry[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[g];
      end else begin : g_mid_right
         assign right_entry = cell_entry[g+1];
      end
      ple_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[g]),
         .value       (req_value),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[g]),
         .match       (match_row[g])
      );
   end

   always_comb begin
      match_low = match_row & (~match_row + CAPACITY'(1));
      found_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_low[i]) begin
            found_idx = found_idx | CMPW'(i + 1);
         end
      end
   end

   always_comb begin
      cnt_next = cnt;
      if (ins_ok) begin
         cnt_next = cnt + ONE_C;
      end else if (rem_ok) begin
         cnt_next = cnt - ONE_C;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_code == REQ_SEARCH) begin
                  state_in = ST_SCAN;
               end else begin
                  count_in     = CW'(cnt_next);
                  out_valid_in = 1'b1;
                  out_data_in  = RSP_TDATA_W'({(cnt_next == '0), (cnt_next == CAP_C),
                                               POS_W'(cnt_next), POS_W'(0),
                                               (ins_ok || rem_ok)});
               end
            end
         end
         ST_SCAN: begin
            state_in     = ST_IDLE;
            out_valid_in = 1'b1;
            out_data_in  = RSP_TDATA_W'({(cnt == '0), (cnt == CAP_C), POS_W'(cnt),
                                         POS_W'(found_idx), (|match_row)});
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> hdl/ple_cell.sv
// One list slot: holds an entry, shifts to or from its neighbors, compares for search.
module ple_cell
   import ple_pkg::*;
(
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic [VALUE_W-1:0] value,
   input  logic [VALUE_W-1:0] left_entry,
   input  logic [VALUE_W-1:0] right_entry,
   output logic [VALUE_W-1:0] entry,
   output logic               match
);

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic               match_ff, match_in;

   always_comb begin
      case (ctrl.op)
         CELL_HOLD:       entry_in = entry_ff;
         CELL_LOAD:       entry_in = value;
         CELL_FROM_LEFT:  entry_in = left_entry;
         CELL_FROM_RIGHT: entry_in = right_entry;
         default:         entry_in = entry_ff;
      endcase
      match_in = ctrl.search && ctrl.live && (entry_ff == value);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

>>> tb/positional_list_shadow.sv
// Shadow list for the positional list engine: watches both channels, predicts and compares.
module positional_list_shadow
   import ple_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // value[31:0], position[36:32], zero fill
   input  logic [REQ_W-1:0]       req_tuser,  // req_type[2:0]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // ok, found_position[5:1],
                                              // entry_count[10:6], is_full, is_empty
   output int                     error_count,
   output int                     awaiting
);

   typedef struct packed {
      logic             is_empty;
      logic             is_full;
      logic [POS_W-1:0] entry_count;
      logic [POS_W-1:0] found_position;
      logic             ok;
   } list_reply_type;

   logic [VALUE_W-1:0] held_values [CAPACITY];
   int                 held = 0;
   int                 errors = 0;
   list_reply_type     reply_queue [$];

   function automatic bit place_value(input int slot, input logic [VALUE_W-1:0] value);
      if (held >= CAPACITY || slot > held) begin
         return 1'b0;
      end
      for (int i = held; i > slot; i--) begin
         held_values[i] = held_values[i-1];
      end
      held_values[slot] = value;
      held++;
      return 1'b1;
   endfunction

   function automatic bit drop_value(input int slot);
      if (slot >= held) begin
         return 1'b0;
      end
      for (int i = slot; i + 1 < held; i++) begin
         held_values[i] = held_values[i+1];
      end
      held--;
      return 1'b1;
   endfunction

   task automatic apply_request(input req_code_type code, input logic [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] position, output list_reply_type reply);
      reply = '0;
      case (code)
         REQ_INS_HEAD: reply.ok = place_value(0, value);
         REQ_INS_POS:  reply.ok = (position != 0) && place_value(int'(position) - 1, value);
         REQ_INS_TAIL: reply.ok = place_value(held, value);
         REQ_REM_HEAD: reply.ok = (held != 0) && drop_value(0);
         REQ_REM_POS:  reply.ok = (position != 0) && drop_value(int'(position) - 1);
         REQ_REM_TAIL: reply.ok = (held != 0) && drop_value(held - 1);
         REQ_SEARCH: begin
            for (int i = 0; i < held && !reply.ok; i++) begin
               if (held_values[i] == value) begin
                  reply.ok = 1'b1;
                  reply.found_position = POS_W'(i + 1);
               end
            end
         end
         default: ;
      endcase
      reply.entry_count = POS_W'(held);
      reply.is_full = (held == CAPACITY);
      reply.is_empty = (held == 0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: rsp %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type got;
      if (reset) begin
         held = 0;
         reply_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(list_reply_type)-1:0];
            if (reply_queue.size() == 0) begin
               $display("%0t: rsp word %h expected none", $time, rsp_tdata);
               errors++;
            end else begin
               want = reply_queue.pop_front();
               compare_field("ok", 32'(want.ok), 32'(got.ok));
               compare_field("found_position", 32'(want.found_position),
                             32'(got.found_position));
               compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
               compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
               compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
               compare_field("fill", 32'(0),
                             32'(rsp_tdata[RSP_TDATA_W-1:$bits(list_reply_type)]));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_code_type'(req_tuser), req_tdata[VALUE_W-1:0],
                          req_tdata[VALUE_W +: POS_W], want);
            reply_queue.push_back(want);
         end
      end
      awaiting <= reply_queue.size();
      error_count <= errors;
   end

endmodule

>>> tb/positional_list_engine_test.sv
// Top of the positional list engine test: clock, reset, request stimulus and verdict.
module positional_list_engine_test;
   import ple_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int ITEM_TARGET = 1750;
   localparam int GROW_PHASE   = 0;
   localparam int SHRINK_PHASE = 1;
   localparam int MIXED_PHASE  = 2;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // value[31:0], position[36:32], zero fill
   logic [REQ_W-1:0]       req_tuser = '0;  // req_type[2:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;      // ok, found_position[5:1],
                                           // entry_count[10:6], is_full, is_empty
   int                     error_count;
   int                     awaiting;
   int                     burst_left = 1;

   positional_list_engine #(.CAPACITY(LIST_DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   positional_list_shadow #(.CAPACITY(LIST_DEPTH)) i_shadow (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .awaiting    (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("positional_list_engine: mismatch");
      $finish;
   end

   initial begin
      int mode;
      int span;
      @(posedge clock);
      while (1) begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 48);
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 4) == 0);
               default: rsp_tready <= i[2];
            endcase
         end
      end
   end

   task automatic send_word(input req_code_type code, input logic [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] position);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {3'b000, position, value};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            req_tdata <= REQ_TDATA_W'({$urandom, $urandom});
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   initial begin
      int                 sent;
      int                 mode;
      int                 span;
      int                 roll;
      int                 insert_share;
      int                 pick;
      req_code_type       code;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(REQ_SEARCH,   32'h0000_0000, 5'd0);
      send_word(REQ_REM_HEAD, 32'h0000_0000, 5'd0);
      send_word(REQ_REM_TAIL, 32'h0000_0000, 5'd0);
      send_word(REQ_REM_POS,  32'h0000_0000, 5'd1);
      send_word(REQ_INS_POS,  32'h0000_0001, 5'd0);
      send_word(REQ_INS_POS,  32'h0000_0001, 5'd2);
      send_word(REQ_INS_HEAD, 32'h8000_0000, 5'd0);
      send_word(REQ_INS_TAIL, 32'h7fff_ffff, 5'd0);
      send_word(REQ_INS_POS,  32'hffff_ffff, 5'd2);
      send_word(REQ_INS_POS,  32'h0000_0000, 5'd4);
      send_word(REQ_INS_POS,  32'h0000_0005, 5'd6);
      send_word(REQ_INS_POS,  32'h0000_0005, 5'd31);
      send_word(REQ_SEARCH,   32'h7fff_ffff, 5'd0);
      send_word(REQ_SEARCH,   32'h0000_0000, 5'd31);
      send_word(REQ_SEARCH,   32'd12345,     5'd0);
      send_word(REQ_UNUSED,   32'hffff_ffff, 5'd31);
      send_word(REQ_INS_HEAD, 32'hffff_ffff, 5'd0);
      send_word(REQ_SEARCH,   32'hffff_ffff, 5'd0);
      send_word(REQ_REM_POS,  32'h0000_0000, 5'd0);
      send_word(REQ_REM_POS,  32'h0000_0000, 5'd6);
      send_word(REQ_REM_POS,  32'h0000_0000, 5'd5);
      send_word(REQ_REM_POS,  32'h0000_0000, 5'd2);
      send_word(REQ_REM_HEAD, 32'h0000_0000, 5'd0);
      send_word(REQ_REM_TAIL, 32'h0000_0000, 5'd0);
      send_word(REQ_REM_POS,  32'h0000_0000, 5'd1);
      wait_for_replies();

      sent = 0;
      while (sent < ITEM_TARGET) begin
         mode = $urandom_range(GROW_PHASE, MIXED_PHASE);
         span = $urandom_range(8, 64);
         insert_share = (mode == GROW_PHASE) ? 70 : (mode == SHRINK_PHASE) ? 20 : 45;
         for (int i = 0; i < span && sent < ITEM_TARGET; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_share) begin
               code = req_code_type'($urandom_range(REQ_INS_HEAD, REQ_INS_TAIL));
            end else if (roll < 88) begin
               code = req_code_type'($urandom_range(REQ_REM_HEAD, REQ_REM_TAIL));
            end else if (roll < 98) begin
               code = REQ_SEARCH;
            end else begin
               code = REQ_UNUSED;
            end
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               value = VALUE_W'($urandom_range(0, 7)) - 32'd4;
            end else if (pick == 4) begin
               value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
               value = $urandom;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               position = '0;
            end else if (pick == 1) begin
               position = POS_W'($urandom_range(18, 31));
            end else if (pick < 4) begin
               position = POS_W'($urandom_range(1, 3));
            end else begin
               position = POS_W'($urandom_range(1, 17));
            end
            send_word(code, value, position);
            sent++;
            if (sent == 600 || sent == 1200) begin
               wait_for_replies();
            end
         end
      end

      wait_for_replies();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("positional_list_engine: match");
      end else begin
         $display("positional_list_engine: mismatch");
      end
      $finish;
   end

endmodule
